>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the following cycle");

`endif

>>> rtl/tmte_pkg.sv
`timescale 1ns / 1ps

package tmte_pkg;

    // Number of mixing rounds after loading and before the tag rounds.
    localparam int INIT_ROUNDS = 1024;

    // Keystream rounds that form the tag.
    localparam int TAG_BITS = 64;

    // Round counter must reach the mixing length and the tag length.
    localparam int ROUND_W = (INIT_ROUNDS > 64) ? $clog2(INIT_ROUNDS) : 6;

    // Register lengths in bits.
    localparam int A_BITS = 80;
    localparam int B_BITS = 88;
    localparam int C_BITS = 88;

    // Item modes.
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_ABSORB = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // Constant bytes used when loading register A.
    localparam logic [7:0] LOAD_FE = 8'hFE;
    localparam logic [7:0] LOAD_FF = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] CFG_NONCE_LOW  = 2'd2;
    localparam logic [1:0] CFG_NONCE_HIGH = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MIX    = 4'b0010,
        ST_ABSORB = 4'b0100,
        ST_TAG    = 4'b1000
    } state_t;

endpackage

>>> rtl/triad_mac_tag_engine.sv
`timescale 1ns / 1ps

// TRIAD-MAC tag engine with one shared round unit.
// Input channel (in_valid, in_stall, mode, data_byte): one item is
// transferred when in_valid is high and in_stall is low. A start item
// loads the registers from the key and nonce and runs 1024 mixing rounds;
// an absorb item feeds data_byte as eight message bits, LSB first; a finish
// item runs 1024 mixing rounds and then 64 keystream rounds forming the tag.
// Mode 3 is taken and ignored.
// One round is done per cycle in the single round unit, but the last
// keystream round waits for a free output slot; in_stall is high until
// an item's rounds end. The tag appears on the output channel (out_valid,
// out_stall, tag) in the cycle after the last keystream round, in an
// output register: a new item may be transferred while the tag waits. If
// the receiver stalls while a later finish completes, the last keystream
// round waits until the slot is free. Configuration (cfg_write, cfg_index,
// cfg_data) is to be written only while idle; the engine does not enforce
// this. Reset clears key, nonce, all three shift registers and out_valid.
module triad_mac_tag_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] tag
);
    import tmte_pkg::*;

    // Register bit p (counted from 1) is held at vector index p-1.
    logic [A_BITS-1:0]  a_reg;
    logic [B_BITS-1:0]  b_reg;
    logic [C_BITS-1:0]  c_reg;
    logic [A_BITS-1:0]  a_load;
    logic [B_BITS-1:0]  b_load;
    logic [C_BITS-1:0]  c_load;

    logic [63:0]        key_low_reg;
    logic [63:0]        key_high_reg;
    logic [63:0]        nonce_low_reg;
    logic [31:0]        nonce_high_reg;

    state_t             state_reg;
    state_t             state_next;
    logic [ROUND_W-1:0] cnt_reg;
    logic               fin_reg;
    logic [7:0]         data_reg;
    logic [TAG_BITS-1:0] acc_reg;
    logic [63:0]        tag_reg;
    logic               out_valid_reg;

    logic               in_xfer;
    logic               out_free;
    logic               step_en;
    logic               msg_bit;
    logic               last_mix;
    logic               last_tag;
    logic               t1;
    logic               t2;
    logic               t3;
    logic               z;
    logic               fb_a;
    logic               fb_b;
    logic               fb_c;

    // Byte of the key or nonce by index, byte n at bits 8n+7..8n.
    function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input int n);
        logic [63:0] w;
        w = (n < 8) ? lo : hi;
        return w[8*(n % 8) +: 8];
    endfunction

    function automatic logic [7:0] nonce_byte(input logic [63:0] lo, input logic [31:0] hi,
                                              input int n);
        logic [63:0] w;
        w = (n < 8) ? lo : {32'd0, hi};
        return w[8*(n % 8) +: 8];
    endfunction

    // Within a byte, bit 7 is the lowest register position.
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Load images of the three registers.
    always_comb
    begin
        a_load[0*8 +: 8] = rev8(nonce_byte(nonce_low_reg, nonce_high_reg, 0));
        a_load[1*8 +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 4));
        a_load[2*8 +: 8] = rev8(LOAD_FF);
        a_load[3*8 +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 3));
        a_load[4*8 +: 8] = rev8(LOAD_FF);
        a_load[5*8 +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 2));
        a_load[6*8 +: 8] = rev8(LOAD_FF);
        a_load[7*8 +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 1));
        a_load[8*8 +: 8] = rev8(LOAD_FE);
        a_load[9*8 +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 0));
        for (int i = 0; i < 11; i++)
        begin
            b_load[8*i +: 8] = rev8(nonce_byte(nonce_low_reg, nonce_high_reg, 11 - i));
            c_load[8*i +: 8] = rev8(key_byte(key_low_reg, key_high_reg, 15 - i));
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                CFG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                default:        key_low_reg    <= key_low_reg;
            endcase
        end
    end

    // Handshake status.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign last_mix = (cnt_reg == ROUND_W'(INIT_ROUNDS - 1));
    assign last_tag = (cnt_reg == ROUND_W'(TAG_BITS - 1));

    // Message bit for the current round.
    always_comb
    begin
        unique case (state_reg)
            ST_MIX:    msg_bit = (cnt_reg == '0);
            ST_ABSORB: msg_bit = data_reg[cnt_reg[2:0]];
            default:   msg_bit = 1'b0;
        endcase
    end

    // A round runs in every busy cycle, except that the final tag round
    // waits for a free output slot.
    always_comb
    begin
        unique case (state_reg) inside
            ST_MIX, ST_ABSORB: step_en = 1'b1;
            ST_TAG:            step_en = !last_tag || out_free;
            default:           step_en = 1'b0;
        endcase
    end

    // Shared round unit: keystream bit and the three feedback bits.
    always_comb
    begin
        t1   = a_reg[67] ^ a_reg[79] ^ (b_reg[84] & c_reg[84]);
        t2   = b_reg[63] ^ b_reg[87];
        t3   = c_reg[67] ^ c_reg[87];
        z    = t1 ^ t2 ^ t3;
        fb_b = t1 ^ (a_reg[72] & a_reg[78]) ^ b_reg[65] ^ msg_bit;
        fb_c = t2 ^ (b_reg[64] & b_reg[86]) ^ c_reg[83] ^ msg_bit;
        fb_a = t3 ^ (c_reg[76] & c_reg[86]) ^ a_reg[73] ^ msg_bit;
    end

    // Shift registers: load on a start transfer, shift on each round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else if (in_xfer && (mode == MODE_START))
        begin
            a_reg <= a_load;
            b_reg <= b_load;
            c_reg <= c_load;
        end
        else if (step_en)
        begin
            a_reg <= {a_reg[A_BITS-2:0], fb_a};
            b_reg <= {b_reg[B_BITS-2:0], fb_b};
            c_reg <= {c_reg[C_BITS-2:0], fb_c};
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode == MODE_START || mode == MODE_FINISH)
                    begin
                        state_next = ST_MIX;
                    end
                    else if (mode == MODE_ABSORB)
                    begin
                        state_next = ST_ABSORB;
                    end
                end
            end
            ST_MIX:
            begin
                if (last_mix)
                begin
                    state_next = fin_reg ? ST_TAG : ST_IDLE;
                end
            end
            ST_ABSORB:
            begin
                if (cnt_reg[2:0] == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAG:
            begin
                if (last_tag && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer registers and round counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                cnt_reg <= '0;
                fin_reg <= (mode == MODE_FINISH);
            end
            else if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else if (step_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Data byte held for the absorb rounds.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_reg <= data_byte;
        end
    end

    // Keystream bits collect in the accumulator; the full tag moves to
    // the output register on the final round.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TAG && step_en)
        begin
            acc_reg[cnt_reg[5:0]] <= z;
            if (last_tag)
            begin
                tag_reg <= {z, acc_reg[TAG_BITS-2:0]};
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_TAG && last_tag && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign tag       = tag_reg;

endmodule

>>> rtl/tmte_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tmte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] tag
);
    import tmte_pkg::*;

    logic in_xfer;
    logic real_cmd;

    assign in_xfer  = in_valid && !in_stall;
    assign real_cmd = (mode == MODE_START) || (mode == MODE_ABSORB) || (mode == MODE_FINISH);

    // Every real command keeps the engine busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, in_xfer && real_cmd, in_stall)

    // The unused mode leaves the engine free for the next transfer.
    `ASSERT_NEXT(a_idle_after_unused, clk, rst_n, in_xfer && !real_cmd, !in_stall)

    // A new tag only appears as the tag rounds end.
    `ASSERT_SAME(a_tag_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A stalled tag is held.
    `ASSERT_NEXT(a_tag_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(tag))

endmodule

bind triad_mac_tag_engine tmte_checker u_tmte_checker (.*);
